// ===== rtl/generational_handle_slot_table_top_defines.svh =====
// Assertion macros for the slot table RTL.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define GHST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another one on the next clock edge.
`define GHST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GHST_ASSERT(lbl, prop, msg)
`define GHST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ghst_pkg.sv =====
`default_nettype none

package ghst_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned HSLOT_W = 8;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_READ   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic             occ;
    logic [GEN_W-1:0] gen;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // A free stack entry keeps the slot together with its next generation.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } stk_t;

endpackage

`default_nettype wire

// ===== rtl/ghst_if.sv =====
`default_nettype none

interface ghst_req_if;
  import ghst_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                handle_valid;
  logic [HSLOT_W-1:0]  handle_slot;
  logic [GEN_W-1:0]    handle_generation;
  logic [PAY_W-1:0]    payload_in;

  modport source (
    output valid, req_type, handle_valid, handle_slot, handle_generation, payload_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, handle_valid, handle_slot, handle_generation, payload_in,
    output ready
  );
endinterface

interface ghst_rsp_if;
  import ghst_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [HSLOT_W-1:0] out_slot;
  logic [GEN_W-1:0]   out_generation;
  logic [PAY_W-1:0]   payload_out;

  modport source (
    output valid, ok, out_slot, out_generation, payload_out,
    input  ready
  );
  modport sink (
    input  valid, ok, out_slot, out_generation, payload_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ghst_ram.sv =====
`default_nettype none

module ghst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/generational_handle_slot_table_top.sv =====
// Generational handle slot table.
// Request and memory reads are registered at the transfer; execute stores the
//   result once the output register is free. Requests are taken only in idle,
//   after the entry memory's registered read, modify and write back.
// Reset: asynchronous, active low; clears used count, free depth, FSM and
//   output valid. The memories are not cleared and need no clearing pass.
`default_nettype none

`include "generational_handle_slot_table_top_defines.svh"

module generational_handle_slot_table_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ghst_req_if.sink    req_i,
  ghst_rsp_if.source  rsp_o
);
  import ghst_pkg::*;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  used_count_q, used_count_d;
  logic [CNT_W-1:0]  free_depth_q, free_depth_d;

  // Request captured at the transfer, used during execute.
  logic [REQ_W-1:0]  req_type_q;
  logic              handle_valid_q;
  logic [HSLOT_W-1:0] handle_slot_q;
  logic [GEN_W-1:0]  handle_gen_q;
  logic [PAY_W-1:0]  payload_in_q;

  // Output register: holds a finished result until the sink takes it.
  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  logic [HSLOT_W-1:0] out_slot_q, out_slot_d;
  logic [GEN_W-1:0]  out_gen_q, out_gen_d;
  logic [PAY_W-1:0]  out_pay_q, out_pay_d;

  logic req_xfer;
  logic commit;

  // Memory ports
  logic              ent_we;
  logic [SLOT_W-1:0] ent_waddr;
  entry_t            ent_wdata;
  entry_t            ent_rdata;
  logic              stk_we;
  logic [SLOT_W-1:0] stk_waddr;
  stk_t              stk_wdata;
  stk_t              stk_rdata;
  logic [CNT_W-1:0]  free_top;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  // Execute finishes only when the output register is free or being drained.
  assign commit      = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);
  assign free_top    = free_depth_q - CNT_W'(1);

  // ---------------------------------------------------------------------
  // Memories: entry store and free-slot stack. Both are read at the
  // request transfer so their data is ready in the execute cycle.
  // ---------------------------------------------------------------------
  ghst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (req_xfer),
    .raddr_i (req_i.handle_slot[SLOT_W-1:0]),
    .rdata_o (ent_rdata)
  );

  ghst_ram #(
    .WIDTH ($bits(stk_t)),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (req_xfer),
    .raddr_i (free_top[SLOT_W-1:0]),
    .rdata_o (stk_rdata)
  );

  // ---------------------------------------------------------------------
  // Execute: check the handle, modify the entry, write it back.
  // ---------------------------------------------------------------------
  logic             live;
  logic [GEN_W-1:0] gen_inc;

  assign live = handle_valid_q
             && ({{(CNT_W-HSLOT_W){1'b0}}, handle_slot_q} < used_count_q)
             && ent_rdata.occ
             && (ent_rdata.gen == handle_gen_q);
  assign gen_inc = ent_rdata.gen + GEN_W'(1);

  always_comb begin
    used_count_d = used_count_q;
    free_depth_d = free_depth_q;
    ent_we       = 1'b0;
    ent_waddr    = handle_slot_q[SLOT_W-1:0];
    ent_wdata    = ent_rdata;
    stk_we       = 1'b0;
    stk_waddr    = free_depth_q[SLOT_W-1:0];
    stk_wdata    = '{slot: handle_slot_q[SLOT_W-1:0], gen: gen_inc};
    ok_d         = 1'b0;
    out_slot_d   = '0;
    out_gen_d    = '0;
    out_pay_d    = '0;

    unique case (req_type_q)
      REQ_ADD: begin
        priority if (free_depth_q != '0) begin
          // Pop a freed slot; its generation travels on the stack.
          free_depth_d = free_top;
          ent_we       = 1'b1;
          ent_waddr    = stk_rdata.slot;
          ent_wdata    = '{occ: 1'b1, gen: stk_rdata.gen, pay: payload_in_q};
          ok_d         = 1'b1;
          out_slot_d   = HSLOT_W'(stk_rdata.slot);
          out_gen_d    = stk_rdata.gen;
        end else if (used_count_q < CNT_W'(SLOTS)) begin
          // Grow into a slot unused since the last clear, at generation zero.
          used_count_d = used_count_q + CNT_W'(1);
          ent_we       = 1'b1;
          ent_waddr    = used_count_q[SLOT_W-1:0];
          ent_wdata    = '{occ: 1'b1, gen: '0, pay: payload_in_q};
          ok_d         = 1'b1;
          out_slot_d   = HSLOT_W'(used_count_q[SLOT_W-1:0]);
        end else begin
          // Table full: answer with ok low and change nothing.
        end
      end
      REQ_WRITE: begin
        if (live) begin
          ent_we        = 1'b1;
          ent_wdata.pay = payload_in_q;
          ok_d          = 1'b1;
        end
      end
      REQ_READ: begin
        if (live) begin
          out_pay_d = ent_rdata.pay;
          ok_d      = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (live) begin
          ent_we    = 1'b1;
          ent_wdata = '{occ: 1'b0,
                        gen: (ent_rdata.gen == GEN_MAX) ? ent_rdata.gen : gen_inc,
                        pay: '0};
          // Retire a slot at the last generation; free the rest.
          if (ent_rdata.gen != GEN_MAX && free_depth_q < CNT_W'(SLOTS)) begin
            stk_we       = 1'b1;
            free_depth_d = free_depth_q + CNT_W'(1);
          end
          ok_d = 1'b1;
        end
      end
      REQ_CLEAR: begin
        used_count_d = '0;
        free_depth_d = '0;
        ok_d         = 1'b1;
      end
      default: begin
        // Unknown request: answer with ok low, touch nothing.
      end
    endcase

    // Hold all side effects until the result can be stored.
    if (!commit) begin
      used_count_d = used_count_q;
      free_depth_d = free_depth_q;
      ent_we       = 1'b0;
      stk_we       = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and output handshake
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_count_q <= '0;
      free_depth_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_count_q <= used_count_d;
      free_depth_q <= free_depth_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_type_q     <= req_i.req_type;
      handle_valid_q <= req_i.handle_valid;
      handle_slot_q  <= req_i.handle_slot;
      handle_gen_q   <= req_i.handle_generation;
      payload_in_q   <= req_i.payload_in;
    end
    if (commit) begin
      ok_q       <= ok_d;
      out_slot_q <= out_slot_d;
      out_gen_q  <= out_gen_d;
      out_pay_q  <= out_pay_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = ok_q;
  assign rsp_o.out_slot       = out_slot_q;
  assign rsp_o.out_generation = out_gen_q;
  assign rsp_o.payload_out    = out_pay_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Every freed slot was handed out before, so the stack never outgrows it.
  `GHST_ASSERT(a_free_le_used, free_depth_q <= used_count_q, "free depth above used count")
  `GHST_ASSERT(a_used_bound, used_count_q <= CNT_W'(SLOTS), "used count above table size")
  // A transfer always leads into execute on the next edge.
  `GHST_ASSERT_NEXT(a_xfer_exec, req_xfer, state_q == S_EXEC, "transfer not followed by execute")
  // A new result appears only out of an execute cycle.
  `GHST_ASSERT(a_rsp_from_exec, $rose(out_valid_q) |-> $past(state_q == S_EXEC),
               "result without execute")

endmodule

`default_nettype wire

// ===== sim/generational_handle_slot_table_top_tb.sv =====
`timescale 1ns / 100ps

module generational_handle_slot_table_top_tb;
  import ghst_pkg::*;

  // Request codes above clear are reserved; the table must ignore them.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_W'(REQ_CLEAR + 1);
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;

  // Hard stop for a hung handshake; the slowest correct run is far below this.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // Cycles to keep watching after the last result for stray transfers.
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic               hvalid;
    logic [HSLOT_W-1:0] hslot;
    logic [GEN_W-1:0]   hgen;
    logic [PAY_W-1:0]   pay;
  } table_req_t;

  typedef struct {
    logic               ok;
    logic [HSLOT_W-1:0] slot;
    logic [GEN_W-1:0]   gen;
    logic [PAY_W-1:0]   pay;
  } table_rsp_t;

  // Operation mix and idling of one stretch of random traffic.
  typedef struct {
    int unsigned n;
    int unsigned w_add;
    int unsigned w_wr;
    int unsigned w_rd;
    int unsigned w_rm;
    int unsigned w_clr;
    int unsigned w_unk;
    int unsigned gap_tx;
    int unsigned gap_rx;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ghst_req_if req_if ();
  ghst_rsp_if rsp_if ();

  generational_handle_slot_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table, advanced once per request transfer.
  int unsigned      tbl_used = 0;
  int unsigned      tbl_depth = 0;
  bit               tbl_occ   [SLOTS];
  bit [GEN_W-1:0]   tbl_gen   [SLOTS];
  bit [PAY_W-1:0]   tbl_pay   [SLOTS];
  int unsigned      tbl_free  [SLOTS];

  table_req_t  req_pending_q[$];   // requests not yet offered to the table
  table_rsp_t  slot_results_q[$];  // predicted answers, oldest first
  table_req_t  req_cur;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned gap_tx_max;
  int unsigned gap_rx_max;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Apply one request to the shadow table and return the answer it must produce.
  function automatic table_rsp_t apply_table_op(input table_req_t r);
    table_rsp_t  res;
    int unsigned s;
    bit          got;
    bit          live;
    res  = '{ok: 1'b0, slot: '0, gen: '0, pay: '0};
    got  = 1'b0;
    s    = 0;
    live = r.hvalid && (r.hslot < tbl_used) && tbl_occ[r.hslot] &&
           (tbl_gen[r.hslot] == r.hgen);
    case (r.req)
      REQ_ADD: begin
        // Reuse the most recently freed slot first, else grow into a fresh one.
        if (tbl_depth != 0) begin
          tbl_depth--;
          s   = tbl_free[tbl_depth];
          got = 1'b1;
        end else if (tbl_used < SLOTS) begin
          s          = tbl_used;
          tbl_used++;
          tbl_gen[s] = '0;
          got        = 1'b1;
        end
        if (got) begin
          tbl_pay[s] = r.pay;
          tbl_occ[s] = 1'b1;
          res.ok     = 1'b1;
          res.slot   = s[HSLOT_W-1:0];
          res.gen    = tbl_gen[s];
        end
      end
      REQ_WRITE: begin
        if (live) begin
          tbl_pay[r.hslot] = r.pay;
          res.ok           = 1'b1;
        end
      end
      REQ_READ: begin
        if (live) begin
          res.pay = tbl_pay[r.hslot];
          res.ok  = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (live) begin
          tbl_occ[r.hslot] = 1'b0;
          tbl_pay[r.hslot] = '0;
          // A slot at the last generation is retired and never handed out again.
          if (tbl_gen[r.hslot] != GEN_MAX) begin
            tbl_gen[r.hslot]++;
            if (tbl_depth < SLOTS) begin
              tbl_free[tbl_depth] = 32'(r.hslot);
              tbl_depth++;
            end
          end
          res.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        tbl_used  = 0;
        tbl_depth = 0;
        res.ok    = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic hv,
                           input logic [HSLOT_W-1:0] hs, input logic [GEN_W-1:0] hg,
                           input logic [PAY_W-1:0] pay);
    table_req_t r;
    r = '{req: kind, hvalid: hv, hslot: hs, hgen: hg, pay: pay};
    req_pending_q.insert(req_pending_q.size(), r);
  endtask

  // Request driver: predict on every transfer, then hold or advance the channel.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    if (!rst_ni) begin
      req_if.valid             <= 1'b0;
      req_if.req_type          <= '0;
      req_if.handle_valid      <= 1'b0;
      req_if.handle_slot       <= '0;
      req_if.handle_generation <= '0;
      req_if.payload_in        <= '0;
      tx_wait                  <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        slot_results_q.insert(slot_results_q.size(), apply_table_op(req_cur));
      end
      if (!req_if.valid || req_if.ready) begin
        if (tx_wait != 0) begin
          tx_wait      <= tx_wait - 1;
          req_if.valid <= 1'b0;
        end else if (req_pending_q.size() != 0) begin
          req_cur                   = req_pending_q.pop_front();
          req_if.req_type          <= req_cur.req;
          req_if.handle_valid      <= req_cur.hvalid;
          req_if.handle_slot       <= req_cur.hslot;
          req_if.handle_generation <= req_cur.hgen;
          req_if.payload_in        <= req_cur.pay;
          req_if.valid             <= 1'b1;
          // Draw the gap that follows this transfer.
          tx_wait                  <= $urandom_range(0, gap_tx_max);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check every transfer, then draw a stall before the next one.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    table_rsp_t  act;
    table_rsp_t  want;
    int unsigned hold;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        act = '{ok: rsp_if.ok, slot: rsp_if.out_slot, gen: rsp_if.out_generation,
                pay: rsp_if.payload_out};
        if (slot_results_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: result with nothing outstanding: ok=%0b slot=%0d gen=%h pay=%h",
                     $realtime, act.ok, act.slot, act.gen, act.pay);
          mismatch_cnt++;
        end else begin
          want = slot_results_q.pop_front();
          if (act.ok !== want.ok || act.slot !== want.slot ||
              act.gen !== want.gen || act.pay !== want.pay) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch exp ok/slot/gen/pay=%0b/%0d/%h/%h got %0b/%0d/%h/%h",
                       $realtime, want.ok, want.slot, want.gen, want.pay,
                       act.ok, act.slot, act.gen, act.pay);
            mismatch_cnt++;
          end
        end
        hold = $urandom_range(0, gap_rx_max);
      end else begin
        hold = (rx_wait != 0) ? rx_wait - 1 : 0;
      end
      rx_wait      <= hold;
      rsp_if.ready <= (hold == 0);
    end
  end

  // Watchdog on a stuck handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL generational_handle_slot_table_top");
      $finish;
    end
  end

  initial begin
    phase_t                phases [5];
    table_req_t            it;
    logic [REQ_W-1:0]      kind;
    int unsigned           pick;
    int unsigned           tot;
    int unsigned           s;

    // Hold the table in reset; the driver and monitor park their outputs.
    rst_ni                   = 1'b0;
    gap_tx_max               = 14;
    gap_rx_max               = 14;

    // Warm-up, fill to capacity without idling, remove-heavy churn, add/remove
    // balance with clears, then a mixed tail.
    phases[0] = '{n: 120, w_add: 35, w_wr: 15, w_rd: 20, w_rm: 20, w_clr: 2, w_unk: 3,
                  gap_tx: 14, gap_rx: 14};
    phases[1] = '{n: 450, w_add: 75, w_wr: 5, w_rd: 10, w_rm: 5, w_clr: 0, w_unk: 2,
                  gap_tx: 0, gap_rx: 0};
    phases[2] = '{n: 300, w_add: 25, w_wr: 15, w_rd: 20, w_rm: 35, w_clr: 1, w_unk: 2,
                  gap_tx: 14, gap_rx: 0};
    phases[3] = '{n: 200, w_add: 40, w_wr: 5, w_rd: 10, w_rm: 40, w_clr: 3, w_unk: 2,
                  gap_tx: 0, gap_rx: 14};
    phases[4] = '{n: 230, w_add: 35, w_wr: 15, w_rd: 20, w_rm: 20, w_clr: 2, w_unk: 3,
                  gap_tx: 14, gap_rx: 14};

    // Directed opening: bad handles on an empty table, reuse through the free
    // stack, stale generations, reserved codes and clear.
    queue_req(REQ_READ, 1'b0, '0, '0, '0);
    queue_req(REQ_WRITE, 1'b1, '0, '0, '1);
    queue_req(REQ_ADD, 1'b0, '1, '1, '1);
    queue_req(REQ_ADD, 1'b1, '0, '0, '0);
    queue_req(REQ_READ, 1'b1, 8'd0, '0, '0);
    queue_req(REQ_READ, 1'b1, 8'd0, '1, '0);
    queue_req(REQ_READ, 1'b0, 8'd0, '0, '0);
    queue_req(REQ_WRITE, 1'b1, 8'd1, '0, 32'hA5A5_5A5A);
    queue_req(REQ_READ, 1'b1, 8'd1, '0, '0);
    queue_req(REQ_REMOVE, 1'b1, 8'd0, '0, '0);
    queue_req(REQ_READ, 1'b1, 8'd0, '0, '0);
    queue_req(REQ_REMOVE, 1'b1, 8'd0, 32'd1, '0);
    queue_req(REQ_ADD, 1'b1, '0, '0, 32'h1234_5678);
    queue_req(REQ_READ, 1'b1, 8'd0, 32'd1, '0);
    queue_req(REQ_READ, 1'b1, '1, '0, '0);
    for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
      queue_req(REQ_W'(k), 1'b1, 8'd0, 32'd1, '1);
    queue_req(REQ_CLEAR, 1'b0, '0, '0, '0);
    queue_req(REQ_READ, 1'b1, 8'd1, '0, '0);
    queue_req(REQ_ADD, 1'b1, '0, '0, 32'h8000_0001);
    queue_req(REQ_REMOVE, 1'b1, 8'd0, '0, '0);
    queue_req(REQ_REMOVE, 1'b1, 8'd0, '0, '0);
    queue_req(REQ_WRITE, 1'b1, 8'd0, 32'd1, 32'h7FFF_FFFE);
    queue_req(REQ_ADD, 1'b1, '0, '0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (phases[p]) begin
      // Hold off the sender until the table has answered everything so far.
      while (req_pending_q.size() != 0 || req_if.valid || slot_results_q.size() != 0)
        @(negedge clk_i);
      gap_tx_max = phases[p].gap_tx;
      gap_rx_max = phases[p].gap_rx;
      tot = phases[p].w_add + phases[p].w_wr + phases[p].w_rd + phases[p].w_rm +
            phases[p].w_clr + phases[p].w_unk;
      for (int i = 0; i < phases[p].n; i++) begin
        // Build each request from the current table so most handles are live.
        while (req_pending_q.size() != 0) @(negedge clk_i);
        pick = $urandom_range(0, tot - 1);
        if (pick < phases[p].w_add)
          kind = REQ_ADD;
        else if (pick < phases[p].w_add + phases[p].w_wr)
          kind = REQ_WRITE;
        else if (pick < phases[p].w_add + phases[p].w_wr + phases[p].w_rd)
          kind = REQ_READ;
        else if (pick < phases[p].w_add + phases[p].w_wr + phases[p].w_rd + phases[p].w_rm)
          kind = REQ_REMOVE;
        else if (pick < tot - phases[p].w_unk)
          kind = REQ_CLEAR;
        else
          kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        it.req    = kind;
        it.hvalid = 1'b1;
        it.hslot  = HSLOT_W'($urandom());
        it.hgen   = $urandom();
        if (tbl_used != 0) begin
          s = 0;
          for (int t = 0; t < 8; t++) begin
            s = $urandom_range(0, tbl_used - 1);
            if (tbl_occ[s]) break;
          end
          it.hslot = HSLOT_W'(s);
          it.hgen  = tbl_gen[s];
        end
        // Corrupt a share of the handles: null, wrong or stale generation, stray slot.
        case ($urandom_range(0, 19))
          0: it.hvalid = 1'b0;
          1: it.hgen = $urandom();
          2: it.hgen = it.hgen - 1;
          3: it.hslot = HSLOT_W'($urandom_range(0, 255));
          4: begin
            it.hvalid = 1'($urandom_range(0, 1));
            it.hslot  = HSLOT_W'($urandom());
            it.hgen   = $urandom();
          end
          default: ;
        endcase
        case ($urandom_range(0, 15))
          0:       it.pay = '0;
          1:       it.pay = '1;
          default: it.pay = $urandom();
        endcase
        req_pending_q.insert(req_pending_q.size(), it);
        @(negedge clk_i);
      end
    end

    while (req_pending_q.size() != 0 || req_if.valid || slot_results_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && slot_results_q.size() == 0)
      $display("PASS generational_handle_slot_table_top");
    else
      $display("FAIL generational_handle_slot_table_top");
    $finish;
  end

endmodule
